>>> hw/rtl/cb32_pkg.sv
// ----------------------------------------------------------------------------
// cb32_pkg
// Shared types, constants and the character lookup of the Crockford base32
// identifier decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cb32_pkg;

  localparam int unsigned SymW     = 8;
  localparam int unsigned ValW     = 5;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned AccW     = 2 * HalfW;
  localparam int unsigned CountW   = 5;

  localparam logic [CountW-1:0] IdSymbols = CountW'(26);
  localparam logic [CountW-1:0] CountSat  = CountW'(27);

  localparam logic [7:0] NotASymbol = 8'hFF;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

  // Symbol values of A..Z; NotASymbol for I, L, O, U.
  localparam logic [7:0] LetterValue [26] = '{
    8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11,
    8'hFF, 8'h12, 8'h13, 8'hFF, 8'h14, 8'h15, 8'hFF, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1A, 8'hFF, 8'h1B, 8'h1C, 8'h1D,
    8'h1E, 8'h1F
  };

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
  } cb32_in_t;

  typedef struct packed {
    logic             valid_res;
    logic [HalfW-1:0] id_high;
    logic [HalfW-1:0] id_low;
  } cb32_out_t;

  typedef struct packed {
    logic            bad;
    logic [ValW-1:0] value;
  } cb32_sym_t;

  // Map one ASCII byte to its 5-bit symbol; bad flags a non-alphabet byte.
  function automatic cb32_sym_t cb32_decode(logic [SymW-1:0] c);
    cb32_sym_t   r;
    logic [7:0]  u;
    logic [7:0]  lv;
    logic [7:0]  idx;
    r   = '{bad: 1'b1, value: '0};
    u   = c;
    lv  = NotASymbol;
    idx = '0;
    if (c >= CharZero && c <= CharNine) begin
      idx = c - CharZero;
      r   = '{bad: 1'b0, value: idx[ValW-1:0]};
    end else begin
      if (c >= CharLowA && c <= CharLowZ) begin
        u = c - CaseOffset;
      end
      if (u >= CharUpA && u <= CharUpZ) begin
        idx = u - CharUpA;
        lv  = LetterValue[idx[4:0]];
        if (lv != NotASymbol) begin
          r = '{bad: 1'b0, value: lv[ValW-1:0]};
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cb32_in_stage.sv
// ----------------------------------------------------------------------------
// cb32_in_stage
// Input register: captures one character request per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  cb32_pkg::cb32_in_t  in_req_i,
  input  wire                 adv_i,
  output logic                valid_o,
  output cb32_pkg::cb32_in_t  req_o
);

  logic               valid_q, valid_d;
  cb32_pkg::cb32_in_t req_q;
  logic               load;

  // Full and not draining: hold off the sender.
  assign in_stall_o = valid_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

>>> hw/rtl/cb32_accum.sv
// ----------------------------------------------------------------------------
// cb32_accum
// Symbol lookup, 128-bit shift accumulator, count and final check.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_accum (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 fire_i,
  input  cb32_pkg::cb32_in_t  req_i,
  output logic                rsp_fire_o,
  output cb32_pkg::cb32_out_t rsp_o
);

  logic [cb32_pkg::AccW-1:0]   acc_q, acc_d, acc_nx;
  logic [cb32_pkg::CountW-1:0] count_q, count_d, count_nx;
  logic                        bad_q, bad_d, bad_nx;
  cb32_pkg::cb32_sym_t         sym;

  assign sym      = cb32_pkg::cb32_decode(req_i.symbol);
  assign acc_nx   = {acc_q[cb32_pkg::AccW-cb32_pkg::ValW-1:0], sym.value};
  assign count_nx = (count_q < cb32_pkg::CountSat) ? count_q + 1'b1 : count_q;
  assign bad_nx   = bad_q || sym.bad;

  always_comb begin
    acc_d   = acc_q;
    count_d = count_q;
    bad_d   = bad_q;
    if (fire_i) begin
      if (req_i.last) begin
        acc_d   = '0;
        count_d = '0;
        bad_d   = 1'b0;
      end else begin
        acc_d   = acc_nx;
        count_d = count_nx;
        bad_d   = bad_nx;
      end
    end
  end

  always_comb begin
    rsp_fire_o = fire_i && req_i.last;
    rsp_o      = '0;
    if (!bad_nx && count_nx == cb32_pkg::IdSymbols) begin
      rsp_o.valid_res = 1'b1;
      rsp_o.id_high   = acc_nx[cb32_pkg::AccW-1:cb32_pkg::HalfW];
      rsp_o.id_low    = acc_nx[cb32_pkg::HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      count_q <= count_d;
      bad_q   <= bad_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cb32_pkg::CountSat)
    else $error("symbol count past saturation");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.last |=> count_q == '0 && !bad_q && acc_q == '0)
    else $error("state not cleared after last character");
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(count_q) && $stable(bad_q))
    else $error("state moved without a character");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid_res |-> rsp_o.id_high == '0 && rsp_o.id_low == '0)
    else $error("invalid result carries nonzero id");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/cb32_out_stage.sv
// ----------------------------------------------------------------------------
// cb32_out_stage
// Result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_out_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  cb32_pkg::cb32_out_t rsp_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output cb32_pkg::cb32_out_t out_rsp_o
);

  logic                valid_q, valid_d;
  cb32_pkg::cb32_out_t rsp_q;

  // Free when empty or draining this cycle.
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

>>> hw/rtl/crockford_base32_id_decoder_unit.sv
// ----------------------------------------------------------------------------
// crockford_base32_id_decoder_unit
// Decodes a 26-character Crockford base32 identifier into a 128-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i): one ASCII character
//   per request, with last set on the final character of the string.
//   Output channel (out_valid_o / out_stall_i / out_rsp_o): one request per
//   string, sent for the character marked last. valid_res is set only when
//   exactly 26 alphabet characters arrived (either case, no I, L, O, U);
//   otherwise id_high and id_low are zero. The first symbol's top two bits
//   fall off the 128-bit accumulator.
// Path: a last character accepted into the input register moves on to the
//   result register and so to out_*, once the result register is free;
//   until then it waits in the input register.
// Throughput: one character per cycle, except while a last character waits
//   for the result register; plain characters never touch the output stage.
// Stall: a stalled result holds in the result register; a last character
//   then waits in the input register and in_stall_o rises for new requests.
// Reset: clears the accumulator, count and both stage valids; no clearing
//   pass is needed. After every last character the state clears again.
// ----------------------------------------------------------------------------
`default_nettype none

module crockford_base32_id_decoder_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  cb32_pkg::cb32_in_t  in_req_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output cb32_pkg::cb32_out_t out_rsp_o
);

  logic                in_valid_q;
  cb32_pkg::cb32_in_t  in_req_q;
  logic                adv;
  logic                out_ready;
  logic                rsp_fire;
  cb32_pkg::cb32_out_t rsp;

  // A plain character always drains; a last one needs room for its result.
  assign adv = in_valid_q && (!in_req_q.last || out_ready);

  cb32_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .adv_i      (adv),
    .valid_o    (in_valid_q),
    .req_o      (in_req_q)
  );

  // Lookup, shift and final length/alphabet check in one pass.
  cb32_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .req_i      (in_req_q),
    .rsp_fire_o (rsp_fire),
    .rsp_o      (rsp)
  );

  cb32_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (rsp_fire),
    .rsp_i       (rsp),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

>>> bench/crockford_base32_id_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// crockford_base32_id_decoder_unit_test
// Drives identifier text one character per request into the decoder and
// checks every per-string result against a local decode of the same text.
// Well-formed 26-character ids in mixed case dominate; short, long, broken
// and noise strings cover the rejection paths. Both sides idle at random, a
// long receiver hold-off backs the decoder up, and the sender pauses now and
// then until all outstanding results have drained.
// ----------------------------------------------------------------------------
module crockford_base32_id_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TextChars  = 1500;  // random text length target
  localparam int unsigned IdleLimit  = 5000;  // cycles with no request moving
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned MaxReports = 10;
  localparam int unsigned Settle     = 8;     // result path is two stages deep

  // Crockford alphabet, symbol value = position.
  localparam logic [8*32-1:0] Alphabet   = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
  localparam logic [8*8-1:0]  BadLetters = "ILOUilou";
  localparam logic [5:0]      BadChar    = 6'b10_0000;

  typedef struct {
    cb32_pkg::cb32_in_t req;
    bit                 drain;  // hold this char until every pending id has come back
  } text_char_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  cb32_pkg::cb32_in_t  in_req_i    = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  cb32_pkg::cb32_out_t out_rsp_o;

  text_char_t          text_q[$];
  cb32_pkg::cb32_out_t id_expect_q[$];

  // Local copy of the decoder state.
  logic [cb32_pkg::AccW-1:0]   id_acc     = '0;
  logic [cb32_pkg::CountW-1:0] char_count = '0;
  logic                        bad_seen   = 1'b0;

  // Pacing
  int unsigned snd_gap   = 0;
  int unsigned rsp_wait  = 0;
  bit          snd_burst = 1'b0;
  bit          rcv_burst = 1'b0;
  bit          rcv_hold  = 1'b0;
  bit          char_done = 1'b0;

  // Bookkeeping
  int unsigned         chars_taken  = 0;
  int unsigned         ids_seen     = 0;
  int unsigned         ids_good     = 0;
  int unsigned         ids_rejected = 0;
  int unsigned         in_backed_up = 0;
  int unsigned         idle_cycles  = 0;
  int unsigned         errors       = 0;
  cb32_pkg::cb32_out_t want;

  crockford_base32_id_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  // {bad, value}: lower case folds onto upper case, digits stay as they are.
  function automatic logic [5:0] char_symbol(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
    for (int k = 0; k < 32; k++) begin
      if (Alphabet[8*(31-k) +: 8] == u) return {1'b0, 5'(k)};
    end
    return BadChar;
  endfunction

  // One accepted character: shift it in, and on last queue the id it closes.
  function automatic void model_take_char(cb32_pkg::cb32_in_t r);
    logic [5:0]          s;
    cb32_pkg::cb32_out_t res;
    s = char_symbol(r.symbol);
    if (s[5]) bad_seen = 1'b1;
    // bad chars shift in zero; the top bits of the first symbol drop off
    id_acc = {id_acc[cb32_pkg::AccW-6:0], s[5] ? 5'd0 : s[4:0]};
    if (char_count < cb32_pkg::CountSat) char_count = char_count + 1'b1;
    if (r.last) begin
      res = '0;
      if (!bad_seen && char_count == cb32_pkg::IdSymbols) begin
        res.valid_res = 1'b1;
        res.id_high   = id_acc[cb32_pkg::AccW-1:cb32_pkg::HalfW];
        res.id_low    = id_acc[cb32_pkg::HalfW-1:0];
      end
      id_expect_q.push_back(res);
      id_acc     = '0;
      char_count = '0;
      bad_seen   = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic void queue_char(logic [7:0] c, logic last, bit drain);
    text_char_t t;
    t.req.symbol = c;
    t.req.last   = last;
    t.drain      = drain;
    text_q.push_back(t);
  endfunction

  // Any alphabet symbol, letters in random case.
  function automatic logic [7:0] random_symbol();
    logic [7:0] c;
    c = Alphabet[8*(31-$urandom_range(0, 31)) +: 8];
    if (c >= "A" && $urandom_range(0, 1)) c = c | 8'h20;
    return c;
  endfunction

  // A byte outside the alphabet; the excluded letters get half the weight.
  function automatic logic [7:0] random_junk();
    logic [7:0] c;
    logic [5:0] s;
    if ($urandom_range(0, 1)) begin
      c = BadLetters[8*$urandom_range(0, 7) +: 8];
    end else begin
      do begin
        c = 8'($urandom);
        s = char_symbol(c);
      end while (!s[5]);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: driver at the falling edge, acceptance at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      model_take_char(in_req_i);
      chars_taken++;
      char_done = 1'b1;
      // switch between back-to-back bursts and gappy traffic
      if (chars_taken % 50 == 0) snd_burst = ($urandom_range(0, 3) == 0);
    end else if (in_valid_i) begin
      in_backed_up++;
    end
  end

  always @(negedge clk_i) begin
    // a stalled request holds its payload until it is taken
    if (rst_ni && !(in_valid_i && !char_done)) begin
      char_done = 1'b0;
      if (snd_gap > 0) begin
        snd_gap--;
        in_valid_i <= 1'b0;
      end else if (text_q.size() == 0 ||
                   (text_q[0].drain && id_expect_q.size() != 0 && !rcv_hold)) begin
        in_valid_i <= 1'b0;
      end else begin
        in_req_i   <= text_q[0].req;
        in_valid_i <= 1'b1;
        void'(text_q.pop_front());
        snd_gap = snd_burst ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rcv_hold) begin
      out_stall_i <= 1'b1;
    end else if (rsp_wait > 0) begin
      rsp_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (id_expect_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("ERROR: id result with none pending: valid=%0b high=%h low=%h",
                   out_rsp_o.valid_res, out_rsp_o.id_high, out_rsp_o.id_low);
      end else begin
        want = id_expect_q.pop_front();
        if (out_rsp_o.valid_res !== want.valid_res ||
            out_rsp_o.id_high !== want.id_high || out_rsp_o.id_low !== want.id_low) begin
          errors++;
          if (errors <= MaxReports)
            $display({"ERROR: id %0d: valid exp %0b got %0b, ",
                      "high exp %h got %h, low exp %h got %h"},
                     ids_seen, want.valid_res, out_rsp_o.valid_res, want.id_high,
                     out_rsp_o.id_high, want.id_low, out_rsp_o.id_low);
        end else if (want.valid_res) begin
          ids_good++;
        end else begin
          ids_rejected++;
        end
      end
      ids_seen++;
      rsp_wait = rcv_burst ? 0 : $urandom_range(0, 10);
      if (ids_seen % 8 == 0) rcv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Long receiver hold-off while the sender keeps going: the result register
  // fills, a last char parks in the input register and in_stall_o rises.
  initial begin
    for (int h = 1; h <= 2; h++) begin
      while (chars_taken < h * 500) @(posedge clk_i);
      rcv_hold = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      rcv_hold = 1'b0;
    end
  end

  // Watchdog: nothing moving on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IdleLimit) begin
      $display("ERROR: no request moved for %0d cycles, %0d ids pending",
               IdleLimit, id_expect_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int          kind;
    int          len;
    int          bad_at;
    bit          drain;
    logic [7:0]  c;
    logic        last;

    // Directed: extreme bytes in a two-char string, an excluded letter alone,
    // then an all-ones id whose first symbol loses its top bits (mixed case).
    queue_char(8'h00, 1'b0, 1'b0);
    queue_char(8'hFF, 1'b1, 1'b0);
    queue_char("o", 1'b1, 1'b0);
    for (int k = 0; k < 26; k++) queue_char(k[0] ? "z" : "Z", k == 25, k == 0);

    // Random strings: mostly well-formed ids, then wrong lengths (long ones
    // run the count into saturation), one bad char, and raw noise.
    while (text_q.size() < TextChars) begin
      kind   = $urandom_range(0, 9);
      len    = 26;
      bad_at = -1;
      if (kind == 7) begin
        len = $urandom_range(1, 40);
        if (len == 26) len = 27;
      end
      if (kind == 8) bad_at = $urandom_range(0, 25);
      if (kind == 9) len = $urandom_range(1, 30);
      drain = ($urandom_range(0, 19) == 0);
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1);
        if (kind == 9) begin
          c    = 8'($urandom);
          last = last || ($urandom_range(0, 3) == 0);
        end else if (k == bad_at) begin
          c = random_junk();
        end else begin
          c = random_symbol();
        end
        queue_char(c, last, drain && k == 0);
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (id_expect_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);

    $display("%0d chars in, %0d ids out: %0d decoded, %0d rejected",
             chars_taken, ids_seen, ids_good, ids_rejected);
    $display("input backed up %0d cycles, %0d mismatches", in_backed_up, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
